// ===== design/adp_pkg.sv =====
// Shared types and constants for the archive directory parser.
package adp_pkg;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SIZE      = 3'd1;
    localparam logic [2:0] ST_MAGIC     = 3'd2;
    localparam logic [2:0] ST_COUNT     = 3'd3;
    localparam logic [2:0] ST_TRUNC     = 3'd4;
    localparam logic [2:0] ST_NAMESFULL = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;

    // One classified byte, as it travels from the front part to the back part.
    typedef struct packed {
        logic        char_en;
        logic [21:0] char_addr;
        logic [7:0]  char_val;
        logic        rec_en;
        logic [12:0] rec_index;
        logic [25:0] rec_offset;
        logic [25:0] rec_size;
        logic [21:0] rec_name_off;
        logic [21:0] rec_name_len;
        logic        stat_en;
        logic [2:0]  stat_code;
        logic [13:0] stat_count;
    } t_work;

    // Lower-case letters and turn backslash into slash.
    function automatic logic [7:0] normalize(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b == 8'h5C) r = 8'h2F;
        else if (b >= 8'h41 && b <= 8'h5A) r = b + 8'h20;
        return r;
    endfunction

endpackage

// ===== design/adp_front.sv =====
// Front part: parse state, classify each byte into up to three results.
module adp_front #(
    parameter int INPUT_LIMIT      = 33554432,
    parameter int ENTRY_LIMIT      = 8192,
    parameter int NAME_STORE_BYTES = 4194304
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [25:0]         i_input_size,
    input  logic                i_valid,
    input  logic [7:0]          i_byte_in,
    input  logic                i_last_byte,
    output logic                o_stall,
    output logic                o_push,
    output adp_pkg::t_work      o_work,
    input  logic                i_full
);
    import adp_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_OFFSET, PH_SIZE, PH_NAME} t_phase;

    t_phase      r_phase, n_phase;
    logic [25:0] r_pos, n_pos;
    logic [1:0]  r_fcnt, n_fcnt;
    logic [31:0] r_shift, n_shift;
    logic [13:0] r_decl, n_decl;
    logic [13:0] r_done, n_done;
    logic [22:0] r_cursor, n_cursor;
    logic [22:0] r_nstart, n_nstart;
    logic [31:0] r_off, n_off;
    logic [31:0] r_size, n_size;
    logic        r_fin, n_fin;
    t_work       w;

    logic        take;
    logic [31:0] shifted;
    logic        cur_full;
    logic [32:0] rend;
    logic        range_ok;

    assign o_stall = i_full;
    assign take    = i_valid && !i_full;
    assign shifted = {r_shift[23:0], i_byte_in};
    assign cur_full = (r_cursor >= 23'(NAME_STORE_BYTES));

    // Check the entry's data range against the current size, without wrapping.
    assign rend     = {1'b0, r_off} + {1'b0, r_size};
    assign range_ok = ({1'b0, r_off} <= 33'(i_input_size)) &&
                      (rend <= 33'(i_input_size));

    // Classify the byte and compute the next parse state.
    always_comb begin
        logic [7:0]  mb;
        n_phase = r_phase; n_pos = r_pos; n_fcnt = r_fcnt; n_shift = r_shift;
        n_decl = r_decl; n_done = r_done; n_cursor = r_cursor; n_nstart = r_nstart;
        n_off = r_off; n_size = r_size; n_fin = r_fin;
        w = '0;
        unique case (r_pos[1:0])
            2'd0: mb = 8'h42;
            2'd1: mb = 8'h49;
            2'd2: mb = 8'h47;
            default: mb = 8'h46;
        endcase
        if (!r_fin) begin
            n_pos = r_pos + 26'd1;
            if (r_pos == '0 && (i_input_size < 26'd16 ||
                                {6'd0, i_input_size} > 32'(INPUT_LIMIT))) begin
                w.stat_en = 1'b1; w.stat_code = ST_SIZE; n_fin = 1'b1;
            end else if (r_pos >= i_input_size) begin
                w.stat_en = 1'b1; w.stat_code = ST_TRUNC; n_fin = 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_pos < 26'd4 && i_byte_in != mb) begin
                            w.stat_en = 1'b1; w.stat_code = ST_MAGIC; n_fin = 1'b1;
                        end else if (r_pos >= 26'd8) begin
                            n_shift = shifted;
                            if (r_pos == 26'd11) begin
                                if (shifted > 32'(ENTRY_LIMIT)) begin
                                    w.stat_en = 1'b1; w.stat_code = ST_COUNT;
                                    n_fin = 1'b1;
                                end else begin
                                    n_decl = shifted[13:0];
                                    if (shifted == '0) begin
                                        w.stat_en = 1'b1; w.stat_code = ST_OK;
                                        n_fin = 1'b1;
                                    end else begin
                                        n_phase = PH_OFFSET; n_fcnt = '0;
                                    end
                                end
                            end
                        end
                    end
                    PH_OFFSET, PH_SIZE: begin
                        n_shift = shifted;
                        n_fcnt = r_fcnt + 2'd1;
                        if (r_fcnt == 2'd3) begin
                            if (r_phase == PH_OFFSET) begin
                                n_off = shifted; n_phase = PH_SIZE;
                            end else begin
                                n_size = shifted;
                                n_nstart = r_cursor;
                                n_phase = PH_NAME;
                            end
                        end
                    end
                    default: begin
                        if (i_byte_in != 8'd0) begin
                            if (range_ok && !cur_full) begin
                                w.char_en = 1'b1;
                                w.char_addr = r_cursor[21:0];
                                w.char_val = normalize(i_byte_in);
                            end
                            if (!cur_full) n_cursor = r_cursor + 23'd1;
                        end else if (cur_full) begin
                            w.stat_en = 1'b1; w.stat_code = ST_NAMESFULL; n_fin = 1'b1;
                        end else if (!range_ok) begin
                            w.stat_en = 1'b1; w.stat_code = ST_RANGE; n_fin = 1'b1;
                        end else begin
                            w.char_en = 1'b1;
                            w.char_addr = r_cursor[21:0];
                            w.char_val = 8'd0;
                            w.rec_en = 1'b1;
                            w.rec_index = r_done[12:0];
                            w.rec_offset = r_off[25:0];
                            w.rec_size = r_size[25:0];
                            w.rec_name_off = r_nstart[21:0];
                            w.rec_name_len = 22'(r_cursor - r_nstart);
                            n_cursor = r_cursor + 23'd1;
                            n_done = r_done + 14'd1;
                            if (r_done + 14'd1 >= r_decl) begin
                                w.stat_en = 1'b1; w.stat_code = ST_OK; n_fin = 1'b1;
                            end else begin
                                n_phase = PH_OFFSET; n_fcnt = '0;
                            end
                        end
                    end
                endcase
            end
        end
        w.stat_count = n_done;
        // Close an unfinished run on the last byte and rearm.
        if (i_last_byte) begin
            if (!n_fin) begin
                w.stat_en = 1'b1; w.stat_code = ST_TRUNC;
            end
            n_phase = PH_HEADER; n_pos = '0; n_fcnt = '0; n_shift = '0;
            n_decl = '0; n_done = '0; n_cursor = '0; n_nstart = '0;
            n_off = '0; n_size = '0; n_fin = 1'b0;
        end
    end

    assign o_push = take && (w.char_en || w.rec_en || w.stat_en);
    assign o_work = w;

    // Hold parse state; advance on each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_pos <= '0; r_fcnt <= '0; r_shift <= '0;
            r_decl <= '0; r_done <= '0; r_cursor <= '0; r_nstart <= '0;
            r_off <= '0; r_size <= '0; r_fin <= 1'b0;
        end else if (take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_fcnt <= n_fcnt; r_shift <= n_shift;
            r_decl <= n_decl; r_done <= n_done; r_cursor <= n_cursor;
            r_nstart <= n_nstart; r_off <= n_off; r_size <= n_size;
            r_fin <= n_fin;
        end
    end
endmodule

// ===== design/adp_queue.sv =====
// Short queue of classified work between the front and back parts.
module adp_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  adp_pkg::t_work  i_work,
    output logic            o_full,
    output logic            o_empty,
    input  logic            i_pop,
    output adp_pkg::t_work  o_work
);
    import adp_pkg::*;
    localparam int AW = $clog2(DEPTH);

    t_work         r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rp];

    // Write at the tail, read from the head.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_work;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (i_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

// ===== design/adp_back.sv =====
// Back part: unpack each queued work item into its result transactions.
module adp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  adp_pkg::t_work  i_work,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_kind,
    output logic [21:0]     o_name_addr,
    output logic [7:0]      o_name_char,
    output logic [12:0]     o_entry_index,
    output logic [25:0]     o_data_offset,
    output logic [25:0]     o_data_size,
    output logic [21:0]     o_name_offset,
    output logic [21:0]     o_name_length,
    output logic [2:0]      o_status,
    output logic [13:0]     o_entry_count,
    output logic            o_run_end
);
    import adp_pkg::*;

    logic [1:0] r_sel;    // results of the head item already sent
    logic [1:0] sel;
    logic       has_more, load;

    // Pick the next pending result of the head item.
    always_comb begin
        sel = KIND_STATUS;
        if (r_sel == 2'd0 && i_work.char_en) sel = KIND_CHAR;
        else if (r_sel <= 2'd1 && i_work.rec_en) sel = KIND_RECORD;
        has_more = 1'b0;
        if (sel == KIND_CHAR)   has_more = i_work.rec_en || i_work.stat_en;
        if (sel == KIND_RECORD) has_more = i_work.stat_en;
    end

    assign load  = !i_empty && (!o_valid || !i_stall);
    assign o_pop = load && !has_more;

    // Hold the output register while stalled; load the next result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0; r_sel <= '0;
        end else begin
            if (load) begin
                o_valid <= 1'b1;
                r_sel <= has_more ? sel + 2'd1 : 2'd0;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_kind <= sel;
            o_name_addr <= (sel == KIND_CHAR) ? i_work.char_addr : '0;
            o_name_char <= (sel == KIND_CHAR) ? i_work.char_val : '0;
            o_entry_index <= (sel == KIND_RECORD) ? i_work.rec_index : '0;
            o_data_offset <= (sel == KIND_RECORD) ? i_work.rec_offset : '0;
            o_data_size <= (sel == KIND_RECORD) ? i_work.rec_size : '0;
            o_name_offset <= (sel == KIND_RECORD) ? i_work.rec_name_off : '0;
            o_name_length <= (sel == KIND_RECORD) ? i_work.rec_name_len : '0;
            o_status <= (sel == KIND_STATUS) ? i_work.stat_code : '0;
            o_entry_count <= (sel == KIND_STATUS) ? i_work.stat_count : '0;
            o_run_end <= !has_more;
        end
    end
endmodule

// ===== design/archive_directory_parser_top.sv =====
// Top level of the archive directory parser.
//   channel   direction  handshake            payload
//   in        input      i_valid / o_stall    i_byte_in, i_last_byte
//   out       output     o_valid / i_stall    kind .. run_end
//   cfg       input      i_cfg_valid/o_cfg_ready  i_cfg_data (input_size)
// One byte is taken per cycle while the queue has room; a byte with k results
// sends them out in turn. Results pass through the queue, then the output
// register. Reset is synchronous and clears all parse state and input_size.
// Output stalls fill the four-entry queue, then stall input.
module archive_directory_parser_top #(
    parameter int INPUT_LIMIT      = 33554432,
    parameter int ENTRY_LIMIT      = 8192,
    parameter int NAME_STORE_BYTES = 4194304
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [25:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [21:0] o_name_addr,
    output logic [7:0]  o_name_char,
    output logic [12:0] o_entry_index,
    output logic [25:0] o_data_offset,
    output logic [25:0] o_data_size,
    output logic [21:0] o_name_offset,
    output logic [21:0] o_name_length,
    output logic [2:0]  o_status,
    output logic [13:0] o_entry_count,
    output logic        o_run_end
);
    import adp_pkg::*;

    logic [25:0] r_input_size;
    logic        push, full, empty, pop;
    t_work       f_work, q_work;

    assign o_cfg_ready = 1'b1;

    // Hold the size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_input_size <= '0;
        else if (i_cfg_valid) r_input_size <= i_cfg_data;
    end

    adp_front #(
        .INPUT_LIMIT(INPUT_LIMIT), .ENTRY_LIMIT(ENTRY_LIMIT),
        .NAME_STORE_BYTES(NAME_STORE_BYTES)
    ) u_front (
        .i_clk, .i_rst_n, .i_input_size(r_input_size), .i_valid, .i_byte_in,
        .i_last_byte, .o_stall, .o_push(push), .o_work(f_work), .i_full(full)
    );

    adp_queue #(.DEPTH(4)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_work(f_work), .o_full(full),
        .o_empty(empty), .i_pop(pop), .o_work(q_work)
    );

    adp_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_work(q_work), .o_pop(pop), .o_valid,
        .i_stall, .o_kind, .o_name_addr, .o_name_char, .o_entry_index,
        .o_data_offset, .o_data_size, .o_name_offset, .o_name_length, .o_status,
        .o_entry_count, .o_run_end
    );
endmodule
